// ===== design/ncnc_pkg.sv =====
package ncnc_pkg;

    localparam int MaxClusters = 64;
    localparam int MaxDim      = 64;
    localparam int CiW         = 6;
    localparam int DiW         = 6;
    localparam int AccW        = 38;
    localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

    typedef enum logic [1:0] {
        K_CENTROID  = 2'd0,
        K_THRESHOLD = 2'd1,
        K_SCALER    = 2'd2,
        K_FEATURE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MODEL = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    localparam logic [1:0] RegNumClusters = 2'd0;
    localparam logic [1:0] RegFeatureDim  = 2'd1;
    localparam logic [1:0] RegScalerEn    = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CiW-1:0]     cluster_index;
        logic [DiW-1:0]     dim_index;
        logic signed [15:0] value;
        logic signed [15:0] aux_value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [CiW-1:0]  best_index;
        logic [15:0]     cluster_label;
        logic [AccW-1:0] distance_sq;
        logic            novel;
    } t_out_item;

    // Token passed down the cell chain: the running minimum.
    typedef struct packed {
        logic            valid;
        logic            found;
        logic [CiW-1:0]  idx;
        logic [AccW-1:0] dmin;
    } t_min_tok;

    // Token passed down the chain while accumulating one feature element.
    typedef struct packed {
        logic               valid;
        logic [CiW-1:0]     idx;
        logic signed [15:0] x;
        logic [DiW-1:0]     pos;
    } t_acc_tok;

endpackage

// ===== design/nearest_centroid_novelty_classifier_unit.sv =====
// Channel | Dir | Handshake               | Payload
// input   | in  | i_in_valid / o_in_ready | i_in_item  (t_in_item)
// output  | out | o_out_valid / i_out_ready | o_out_item (t_out_item)
// config  | in  | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// Load items do not hold the input off. A feature element within MaxDim
// holds it off while its token walks the chain of cluster cells through
// each cell's r_tok and r_acc_out registers, and while the divider runs
// when standardisation is on. A last element then sends a minimum token
// down the chain; S_LOOK and S_RES look up the result that S_OUT offers.
// Reset is synchronous and active low; stores are not cleared. One item is
// in flight at a time; a waiting result in the output register stalls input.
module nearest_centroid_novelty_classifier_unit
    import ncnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Control sequencer: one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MIN  = 7'b0001000,
        S_LOOK = 7'b0010000,
        S_RES  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [6:0] r_num_clusters;
    logic [6:0] r_feature_dim;
    logic       r_scaler_en;
    logic [6:0] r_count;
    logic       r_last;
    // One bit wider than the count, so that a saturated count of 127 still
    // gives a length of 128 rather than wrapping to zero.
    logic [7:0] r_len;

    // Per-cluster and per-dimension small stores.
    logic [15:0] r_thr   [MaxClusters];
    logic [15:0] r_label [MaxClusters];
    logic [15:0] r_mean  [MaxDim];
    logic [15:0] r_scale [MaxDim];

    logic [CiW:0] nc;
    logic [6:0]   fd;
    assign nc = (r_num_clusters > 7'(MaxClusters)) ? (CiW+1)'(MaxClusters)
                                                  : r_num_clusters[CiW:0];
    assign fd = (r_feature_dim > 7'(MaxDim)) ? 7'(MaxDim) : r_feature_dim;

    // Configuration port.
    logic wr_cfg;
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            RegNumClusters: prdata = {25'd0, r_num_clusters};
            RegFeatureDim:  prdata = {25'd0, r_feature_dim};
            RegScalerEn:    prdata = {31'd0, r_scaler_en};
            default:        prdata = '0;
        endcase
    end

    logic in_fire;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    t_kind kind;
    assign kind = t_kind'(i_in_item.kind);

    // Standardisation.
    logic [DiW-1:0]     r_pos;
    logic signed [15:0] r_x;
    logic               div_start;
    logic               div_done;
    logic signed [15:0] div_q;
    logic signed [16:0] sdiff;
    logic signed [15:0] sden;
    logic signed [15:0] r_mean_rd;
    logic signed [15:0] r_scale_rd;

    assign sdiff     = 17'(r_x) - 17'(r_mean_rd);
    assign sden      = (r_scale_rd == 16'sd0) ? 16'sd256 : r_scale_rd;

    logic r_div_go;
    assign div_start = r_div_go;

    ncnc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({sdiff, 8'd0}),
        .i_den   (sden),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // Chain.
    t_acc_tok acc_tok [MaxClusters+1];
    t_min_tok min_tok [MaxClusters+1];
    logic     r_clear;
    t_acc_tok r_acc_inj;
    t_min_tok r_min_inj;
    logic     cent_wr;

    assign cent_wr   = in_fire && kind == K_CENTROID;
    assign acc_tok[0] = r_acc_inj;
    assign min_tok[0] = r_min_inj;

    for (genvar g = 0; g < MaxClusters; g++) begin : g_cell
        ncnc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_id     (CiW'(g)),
            .i_wr     (cent_wr),
            .i_wr_ci  (i_in_item.cluster_index),
            .i_wr_di  (i_in_item.dim_index),
            .i_wr_val (i_in_item.value),
            .i_nc     (nc),
            .i_clear  (r_clear),
            .i_acc    (acc_tok[g]),
            .o_acc    (acc_tok[g+1]),
            .i_min    (min_tok[g]),
            .o_min    (min_tok[g+1])
        );
    end

    // Sequencing events.
    logic feat_fire;
    logic feat_room;
    logic div_fin;
    logic min_go;
    logic out_fire;
    assign feat_fire = in_fire && kind == K_FEATURE;
    assign feat_room = (r_count < 7'(MaxDim));
    assign div_fin   = (r_state == S_DIV) && div_done;
    assign min_go    = (feat_fire && !feat_room && i_in_item.last) ||
                       ((r_state == S_ACC) && acc_tok[MaxClusters].valid && r_last);
    assign out_fire  = (r_state == S_OUT) && i_out_ready;

    // Result lookup.
    t_min_tok         r_best;
    logic [15:0]      r_thr_rd;
    logic [15:0]      r_lab_rd;
    logic [15:0]      r_lab0;
    t_out_item        r_out;
    logic signed [15:0] thr_s;
    logic [31:0]      thr_sq;
    assign thr_s  = r_thr_rd;
    assign thr_sq = 32'(thr_s * thr_s);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && kind == K_FEATURE) begin
                    if (r_count < 7'(MaxDim)) begin
                        n_state = r_scaler_en ? S_DIV : S_ACC;
                    end else begin
                        n_state = i_in_item.last ? S_MIN : S_IDLE;
                    end
                end
            end
            S_DIV:  if (div_done) n_state = S_ACC;
            S_ACC:  if (acc_tok[MaxClusters].valid) n_state = r_last ? S_MIN : S_IDLE;
            S_MIN:  if (min_tok[MaxClusters].valid) n_state = S_LOOK;
            S_LOOK: n_state = S_RES;
            S_RES:  n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_num_clusters <= '0;
            r_feature_dim  <= 7'd1;
            r_scaler_en    <= 1'b0;
            r_count        <= '0;
            r_div_go       <= 1'b0;
            r_clear        <= 1'b0;
            r_acc_inj.valid <= 1'b0;
            r_min_inj.valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_go  <= feat_fire && feat_room && r_scaler_en;
            r_clear   <= out_fire;
            if (wr_cfg) begin
                case (paddr[3:2])
                    RegNumClusters: r_num_clusters <= pwdata[6:0];
                    RegFeatureDim:  r_feature_dim  <= pwdata[6:0];
                    RegScalerEn:    r_scaler_en    <= pwdata[0];
                    default: ;
                endcase
            end
            if (feat_fire) begin
                r_len <= 8'(r_count) + 8'd1;
                if (r_count != 7'd127) r_count <= r_count + 7'd1;
            end else if (out_fire) begin
                r_count <= '0;
            end
            if (feat_fire && feat_room && !r_scaler_en) begin
                r_acc_inj <= '{valid: 1'b1, idx: '0, x: i_in_item.value,
                               pos: DiW'(r_count)};
            end else if (div_fin) begin
                r_acc_inj <= '{valid: 1'b1, idx: '0, x: div_q, pos: r_pos};
            end else begin
                r_acc_inj.valid <= 1'b0;
            end
            if (min_go) begin
                r_min_inj <= '{valid: 1'b1, found: 1'b0, idx: '0, dmin: '0};
            end else begin
                r_min_inj.valid <= 1'b0;
            end
        end
        if (in_fire) begin
            r_last     <= i_in_item.last;
            r_x        <= i_in_item.value;
            r_pos      <= DiW'(r_count);
            r_mean_rd  <= r_mean[DiW'(r_count)];
            r_scale_rd <= r_scale[DiW'(r_count)];
            case (kind)
                K_THRESHOLD: begin
                    r_thr[i_in_item.cluster_index]   <= i_in_item.value;
                    r_label[i_in_item.cluster_index] <= i_in_item.aux_value;
                end
                K_SCALER: begin
                    r_mean[i_in_item.dim_index]  <= i_in_item.value;
                    r_scale[i_in_item.dim_index] <= i_in_item.aux_value;
                end
                default: ;
            endcase
        end
        if (r_state == S_MIN && min_tok[MaxClusters].valid) begin
            r_best <= min_tok[MaxClusters];
        end
        if (r_state == S_LOOK) begin
            r_thr_rd <= r_thr[r_best.idx];
            r_lab_rd <= r_label[r_best.idx];
            r_lab0   <= r_label[0];
        end
        if (r_state == S_RES) begin
            if (nc == '0) begin
                r_out <= '{status: ST_NO_MODEL, best_index: '0, cluster_label: '0,
                           distance_sq: '0, novel: 1'b0};
            end else if (r_len != {1'b0, fd}) begin
                r_out <= '{status: ST_MISMATCH, best_index: '0, cluster_label: r_lab0,
                           distance_sq: AccMax, novel: 1'b1};
            end else begin
                r_out <= '{status: ST_OK, best_index: r_best.idx, cluster_label: r_lab_rd,
                           distance_sq: r_best.dmin,
                           novel: thr_s[15] || (r_best.dmin > AccW'(thr_sq))};
            end
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

endmodule

// ===== design/ncnc_div.sv =====
// Restoring divider: signed 25-bit dividend by signed 16-bit divisor,
// one quotient bit per cycle, truncating toward zero, saturated to 16 bits.
module ncnc_div
    import ncnc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [24:0] i_num,
    input  logic signed [15:0] i_den,
    output logic               o_done,
    output logic signed [15:0] o_quo
);

    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg, n_neg;
    logic [24:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic        r_done, n_done;
    logic [17:0] trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_done = 1'b0;
        trial  = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd25;
            n_neg  = i_num[24] ^ i_den[15];
            n_q    = i_num[24] ? 25'(-i_num) : i_num;
            n_rem  = '0;
            n_den  = i_den[15] ? 17'(-{i_den[15], i_den}) : {1'b0, i_den};
        end else if (r_busy) begin
            trial = {r_rem, r_q[24]} - {1'b0, r_den};
            if (!trial[17]) begin
                n_rem = trial[16:0];
                n_q   = {r_q[23:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_q[24]};
                n_q   = {r_q[23:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    always_comb begin
        o_done = r_done;
        if (!r_neg) begin
            o_quo = (r_q > 25'd32767) ? 16'sd32767 : 16'(r_q);
        end else begin
            o_quo = (r_q > 25'd32768) ? -16'sd32768 : 16'(-r_q);
        end
    end

endmodule

// ===== design/ncnc_cell.sv =====
// One cluster cell: holds its centroid row and its distance accumulator.
// The accumulate token and the minimum token both pass through each cell.
module ncnc_cell
    import ncnc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CiW-1:0]    i_id,
    input  logic              i_wr,
    input  logic [CiW-1:0]    i_wr_ci,
    input  logic [DiW-1:0]    i_wr_di,
    input  logic [15:0]       i_wr_val,
    input  logic [CiW:0]      i_nc,
    input  logic              i_clear,
    input  t_acc_tok          i_acc,
    output t_acc_tok          o_acc,
    input  t_min_tok          i_min,
    output t_min_tok          o_min
);

    logic [15:0]        r_row [MaxDim];
    logic [AccW-1:0]    r_acc;
    logic signed [15:0] r_c;
    t_acc_tok           r_tok;
    t_acc_tok           r_acc_out;
    t_min_tok           r_min;
    logic               active;
    logic               take;
    logic signed [16:0] diff;
    logic [33:0]        sq;
    logic [AccW:0]      sum;

    assign active = ({1'b0, i_id} < i_nc);
    assign take   = i_min.valid && active && (!i_min.found || r_acc < i_min.dmin);

    always_ff @(posedge i_clk) begin
        if (i_wr && i_wr_ci == i_id) begin
            r_row[i_wr_di] <= i_wr_val;
        end
        r_c <= r_row[i_acc.pos];
    end

    assign diff = 17'(r_tok.x) - 17'(r_c);
    assign sq   = 34'(diff * diff);
    assign sum  = {1'b0, r_acc} + (AccW+1)'(sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid     <= 1'b0;
            r_acc_out.valid <= 1'b0;
            r_min.valid     <= 1'b0;
            r_acc           <= '0;
        end else begin
            r_tok     <= i_acc;
            r_acc_out <= r_tok;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_tok.valid && active) begin
                r_acc <= sum[AccW] ? AccMax : sum[AccW-1:0];
            end
            r_min <= take ? t_min_tok'{valid: 1'b1, found: 1'b1, idx: i_id, dmin: r_acc}
                          : i_min;
        end
    end

    assign o_acc = r_acc_out;
    assign o_min = r_min;

endmodule
